// ----- rtl/wavs_pkg.sv -----
// shared constants and types of the windowed average scaler
// no dependencies; imported by every module of the block
`default_nettype none

package wavs_pkg;

    localparam int COUNT_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int VOLT_W   = 16;
    localparam int SUM_W    = COUNT_W + SAMPLE_W;
    localparam int NUM_W    = SUM_W + CFG_W;
    localparam int DEN_W    = COUNT_W + CFG_W;
    localparam int DIV_W    = (NUM_W > DEN_W + VOLT_W) ? NUM_W : DEN_W + VOLT_W;
    localparam int STEP_W   = $clog2(VOLT_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [VOLT_W-1:0]  VOLT_MAX  = '1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_SCALE_NUM = 2'd1;
    localparam logic [1:0] REG_SCALE_DEN = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RST    = 16'd100;
    localparam logic [CFG_W-1:0] SCALE_NUM_RST = 16'd220;
    localparam logic [CFG_W-1:0] SCALE_DEN_RST = 16'd273;

    typedef struct packed {
        logic               close;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic [CFG_W-1:0] scale_num;
        logic [CFG_W-1:0] scale_den;
    } scale_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/wavs_front.sv -----
// front end: accepts words, accumulates samples and tests the window
// depends on wavs_pkg
`default_nettype none

module wavs_front
    import wavs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_sample_valid,
    input  wire logic [CODE_W-1:0] s_sample_code,
    input  wire logic [TIME_W-1:0] s_now_ms,
    input  wire logic [CFG_W-1:0]  window_ms,
    input  wire logic              q_ready,
    output logic                   q_push,
    output job_t                   q_job
);

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [SAMPLE_W-1:0] code;
    logic                take;
    logic [SUM_W-1:0]    sum_acc;
    logic [COUNT_W-1:0]  cnt_acc;
    logic [TIME_W-1:0]   elapsed;
    logic                close;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    assign code    = s_sample_code[SAMPLE_W-1:0];
    assign take    = s_sample_valid && (cnt_reg != COUNT_MAX);
    assign sum_acc = sum_reg + (take ? SUM_W'(code) : '0);
    assign cnt_acc = cnt_reg + COUNT_W'(take);
    assign elapsed = s_now_ms - start_reg;
    assign close   = elapsed >= TIME_W'(window_ms);

    assign q_job.close = close && (cnt_acc != '0);
    assign q_job.sum   = sum_acc;
    assign q_job.count = cnt_acc;

    always_comb begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        if (q_push) begin
            if (close) begin
                sum_next   = '0;
                cnt_next   = '0;
                start_next = s_now_ms;
            end else begin
                sum_next = sum_acc;
                cnt_next = cnt_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            start_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
        end
    end

    a_empty_sum : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == '0 |-> sum_reg == '0)
        else $error("sum nonzero with empty window");

    a_close_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && close |=> cnt_reg == '0 && start_reg == $past(s_now_ms))
        else $error("window close did not restart accumulation");

endmodule

`default_nettype wire

// ----- rtl/wavs_queue.sv -----
// two-entry queue of classified words between front and back end
// depends on wavs_pkg
`default_nettype none

module wavs_queue
    import wavs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t in_job,
    output logic      in_ready,
    input  wire logic pop,
    output job_t      out_job,
    output logic      out_valid
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    a_no_overfill : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3 && (cnt_reg != 2'd2 || wr_ptr_reg == rd_ptr_reg))
        else $error("queue fill level inconsistent");

endmodule

`default_nettype wire

// ----- rtl/wavs_back.sv -----
// back end: scales window averages with a shift-subtract divider, drives results
// depends on wavs_pkg
`default_nettype none

module wavs_back
    import wavs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire job_t q_job,
    input  wire logic q_valid,
    output logic      q_pop,
    input  wire scale_cfg_t cfg,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [VOLT_W-1:0] m_voltage_mv,
    output logic              m_fresh
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VOLT_W - 1);

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic [VOLT_W-1:0]   m_voltage_reg, m_voltage_next;
    logic                m_fresh_reg, m_fresh_next;
    logic [VOLT_W-1:0]   held_reg, held_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]    pnum_reg, pnum_next;
    logic [DEN_W-1:0]    pden_reg, pden_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    dsh_reg, dsh_next;
    logic [VOLT_W-1:0]   quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_free;
    logic [CFG_W-1:0]    den_eff;
    logic                rem_ge;

    assign out_free     = !m_valid_reg || m_ready;
    assign den_eff      = (cfg.scale_den == '0) ? CFG_W'(1) : cfg.scale_den;
    assign rem_ge       = rem_reg >= dsh_reg;
    assign q_pop        = (state_reg == ST_IDLE) && q_valid && (q_job.close || out_free);
    assign m_valid      = m_valid_reg;
    assign m_voltage_mv = m_voltage_reg;
    assign m_fresh      = m_fresh_reg;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_voltage_next = m_voltage_reg;
        m_fresh_next   = m_fresh_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        pnum_next      = pnum_reg;
        pden_next      = pden_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    if (q_job.close) begin
                        sum_next   = q_job.sum;
                        cnt_next   = q_job.count;
                        state_next = ST_MUL;
                    end else begin
                        m_valid_next   = 1'b1;
                        m_voltage_next = held_reg;
                        m_fresh_next   = 1'b0;
                    end
                end
            end
            ST_MUL: begin
                pnum_next  = sum_reg * cfg.scale_num;
                pden_next  = cnt_reg * den_eff;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                rem_next  = DIV_W'(pnum_reg);
                dsh_next  = DIV_W'({pden_reg, {(VOLT_W - 1){1'b0}}});
                step_next = STEP_LAST;
                quot_next = '0;
                if (DIV_W'(pnum_reg) >= DIV_W'({pden_reg, {VOLT_W{1'b0}}})) begin
                    quot_next  = VOLT_MAX;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_ge) begin
                    rem_next = rem_reg - dsh_reg;
                end
                quot_next = {quot_reg[VOLT_W-2:0], rem_ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_voltage_next = quot_reg;
                    m_fresh_next   = 1'b1;
                    held_next      = quot_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            m_voltage_reg <= m_voltage_next;
            m_fresh_reg   <= m_fresh_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            pnum_reg      <= pnum_next;
            pden_reg      <= pden_next;
            rem_reg       <= rem_next;
            dsh_reg       <= dsh_next;
            quot_reg      <= quot_next;
            step_reg      <= step_next;
        end
    end

    a_div_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < {dsh_reg, 1'b0})
        else $error("divider remainder out of range");

    a_fresh_out : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free
        |=> m_valid_reg && m_fresh_reg && m_voltage_reg == held_reg)
        else $error("scaled voltage not delivered with fresh mark");

endmodule

`default_nettype wire

// ----- rtl/windowed_adc_average_scaler_top.sv -----
// windowed converter average scaled to millivolts: block top level
// configuration registers and apb port; depends on wavs_pkg, wavs_front,
// wavs_queue and wavs_back
//
// usage:
// - input channel s_*: one word per converter reading (sample_valid,
//   sample_code, now_ms); output channel m_*: one word per input word
//   (voltage_mv, fresh), in input order
// - apb registers: window_ms at 0x0, scale_num at 0x4, scale_den at 0x8;
//   write them only while no word is in flight
// - a word that does not close a window with samples passes through the queue
//   into the output register; a closing word takes a multiply step, a range
//   check and, unless the result saturates, 16 shift-subtract divider steps
// - the divider in the back end limits throughput: one word per cycle between
//   window closes while m_ready stays high; each close holds the back end while
//   the front end keeps accepting until the two-word queue is full
// - reset clears the running sum, count, window start and held voltage, sets
//   register defaults; senders must send no words during reset, unenforced
// - a stalled receiver holds the output register; the queue then fills
//   and s_ready drops
`default_nettype none

module windowed_adc_average_scaler_top
    import wavs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_sample_valid,
    input  wire logic [CODE_W-1:0]  s_sample_code,
    input  wire logic [TIME_W-1:0]  s_now_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [VOLT_W-1:0]       m_voltage_mv,
    output logic                    m_fresh
);

    logic [CFG_W-1:0] window_reg, window_next;
    logic [CFG_W-1:0] num_reg, num_next;
    logic [CFG_W-1:0] den_reg, den_next;
    logic             wr_en;
    logic [1:0]       reg_idx;
    scale_cfg_t       scale_cfg;
    logic             q_ready, q_push, q_valid, q_pop;
    job_t             push_job, head_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        window_next = window_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_WINDOW:    window_next = pwdata[CFG_W-1:0];
                REG_SCALE_NUM: num_next    = pwdata[CFG_W-1:0];
                REG_SCALE_DEN: den_next    = pwdata[CFG_W-1:0];
                default: begin
                    window_next = window_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WINDOW:    prdata = PDATA_W'(window_reg);
            REG_SCALE_NUM: prdata = PDATA_W'(num_reg);
            REG_SCALE_DEN: prdata = PDATA_W'(den_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RST;
            num_reg    <= SCALE_NUM_RST;
            den_reg    <= SCALE_DEN_RST;
        end else begin
            window_reg <= window_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
        end
    end

    assign scale_cfg.scale_num = num_reg;
    assign scale_cfg.scale_den = den_reg;

    wavs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_valid (s_sample_valid),
        .s_sample_code  (s_sample_code),
        .s_now_ms       (s_now_ms),
        .window_ms      (window_reg),
        .q_ready        (q_ready),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    wavs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_job    (push_job),
        .in_ready  (q_ready),
        .pop       (q_pop),
        .out_job   (head_job),
        .out_valid (q_valid)
    );

    wavs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_job        (head_job),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .cfg          (scale_cfg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_voltage_mv (m_voltage_mv),
        .m_fresh      (m_fresh)
    );

endmodule

`default_nettype wire

// ----- verif/tb_windowed_adc_average_scaler_top.sv -----
// self-checking testbench of windowed_adc_average_scaler_top: apb register writes,
// directed and random converter words, per-word prediction of the held voltage
// depends on wavs_pkg and the block rtl only
`timescale 1ns / 100ps

module tb_windowed_adc_average_scaler_top;
    import wavs_pkg::*;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic              fresh;
    } reading_t;

    class voltage_scoreboard;
        logic [CFG_W-1:0]   window_ms;
        logic [CFG_W-1:0]   scale_num;
        logic [CFG_W-1:0]   scale_den;
        logic [SUM_W-1:0]   acc_sum;
        logic [COUNT_W-1:0] acc_count;
        logic [TIME_W-1:0]  win_start;
        logic [VOLT_W-1:0]  held_mv;
        reading_t           volt_q[$];
        int                 mismatches;

        function new();
            window_ms  = WINDOW_RST;
            scale_num  = SCALE_NUM_RST;
            scale_den  = SCALE_DEN_RST;
            acc_sum    = '0;
            acc_count  = '0;
            win_start  = '0;
            held_mv    = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_WINDOW:    window_ms = val;
                REG_SCALE_NUM: scale_num = val;
                REG_SCALE_DEN: scale_den = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return volt_q.size();
        endfunction

        // accumulate first, then the window test with the same word's time
        function void note_word(logic sv, logic [CODE_W-1:0] code, logic [TIME_W-1:0] now);
            logic [CODE_W-1:0] mask;
            logic [TIME_W-1:0] elapsed;
            logic [63:0]       dividend;
            logic [63:0]       divisor;
            logic [63:0]       quo;
            logic [63:0]       den_eff;
            reading_t          r;
            mask = {CODE_W{1'b1}} >> (CODE_W - SAMPLE_W);
            r.fresh = 1'b0;
            if (sv && acc_count != COUNT_MAX) begin
                acc_sum   = acc_sum + (code & mask);
                acc_count = acc_count + 1'b1;
            end
            elapsed = now - win_start;
            if (elapsed >= {16'd0, window_ms}) begin
                if (acc_count != 0) begin
                    den_eff  = (scale_den == 0) ? 64'd1 : {48'd0, scale_den};
                    dividend = {24'd0, acc_sum};
                    dividend = dividend * {48'd0, scale_num};
                    divisor  = {40'd0, acc_count};
                    divisor  = divisor * den_eff;
                    quo      = dividend / divisor;
                    held_mv  = (quo > {48'd0, VOLT_MAX}) ? VOLT_MAX : quo[VOLT_W-1:0];
                    acc_sum   = '0;
                    acc_count = '0;
                    r.fresh   = 1'b1;
                end
                win_start = now;
            end
            r.voltage_mv = held_mv;
            volt_q.push_back(r);
        endfunction

        function void check_word(logic [VOLT_W-1:0] volt, logic fresh);
            reading_t want;
            if (volt_q.size() == 0) begin
                $display("%0t unexpected word: voltage_mv %0d fresh %0b", $time, volt, fresh);
                mismatches++;
                return;
            end
            want = volt_q.pop_front();
            if (volt !== want.voltage_mv) begin
                $display("%0t voltage_mv expected %0d got %0d", $time, want.voltage_mv, volt);
                mismatches++;
            end
            if (fresh !== want.fresh) begin
                $display("%0t fresh expected %0b got %0b", $time, want.fresh, fresh);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_sample_valid;
    logic [CODE_W-1:0]  s_sample_code;
    logic [TIME_W-1:0]  s_now_ms;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [VOLT_W-1:0]  m_voltage_mv;
    logic               m_fresh;

    voltage_scoreboard  sb = new();
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    logic [TIME_W-1:0]  clock_ms;

    windowed_adc_average_scaler_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_valid (s_sample_valid),
        .s_sample_code  (s_sample_code),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_voltage_mv   (m_voltage_mv),
        .m_fresh        (m_fresh)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_voltage_mv, m_fresh);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W-CFG_W){1'b0}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_word(input logic sv, input logic [CODE_W-1:0] code,
                             input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_valid <= sv;
        s_sample_code  <= code;
        s_now_ms       <= now;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(sv, code, now);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    // mostly small forward steps so windows fill; some jumps and backward steps
    task automatic random_words(input int n, input int span);
        int               r;
        logic [CODE_W-1:0] code;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75)      clock_ms = clock_ms + $urandom_range(0, 3);
            else if (r < 88) clock_ms = clock_ms + $urandom_range(0, 2 * span);
            else if (r < 95) clock_ms = $urandom();
            else             clock_ms = clock_ms - $urandom_range(1, 50);
            r = $urandom_range(0, 19);
            if (r == 0)      code = '0;
            else if (r == 1) code = '1;
            else             code = CODE_W'($urandom());
            send_word($urandom_range(0, 99) < 85, code, clock_ms);
        end
    endtask

    task automatic phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] num,
                         input logic [CFG_W-1:0] den, input int idle, input int stall,
                         input int n);
        drain();
        reg_write(REG_WINDOW, win);
        reg_write(REG_SCALE_NUM, num);
        reg_write(REG_SCALE_DEN, den);
        idle_pct  = idle;
        stall_pct = stall;
        random_words(n, (win > 64) ? 64 : win);
    endtask

    initial begin
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_sample_valid <= 1'b0;
        s_sample_code  <= '0;
        s_now_ms       <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults, window edge, empty close, time wrap
        send_word(1'b1, 16'hFFFF, 32'd0);
        send_word(1'b1, 16'h0000, 32'd50);
        send_word(1'b0, 16'h1234, 32'd99);
        send_word(1'b1, 16'hFFFF, 32'd100);
        send_word(1'b0, 16'hFFFF, 32'd250);
        send_word(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(1'b1, 16'h0001, 32'h0000_0010);
        send_word(1'b1, 16'h8000, 32'h0000_0063);
        send_word(1'b1, 16'h5555, 32'hAAAA_AAAA);

        // zero window closes on every word, zero denominator, saturated voltage
        drain();
        reg_write(REG_WINDOW, 16'd0);
        reg_write(REG_SCALE_NUM, 16'hFFFF);
        reg_write(REG_SCALE_DEN, 16'd0);
        send_word(1'b1, 16'hFFFF, 32'h5555_5555);
        send_word(1'b0, 16'h00FF, 32'h5555_5555);
        send_word(1'b1, 16'h0000, 32'h5555_5556);
        send_word(1'b1, 16'h0001, 32'h0000_0000);

        // smallest scale, longest window
        drain();
        reg_write(REG_WINDOW, 16'hFFFF);
        reg_write(REG_SCALE_NUM, 16'd1);
        reg_write(REG_SCALE_DEN, 16'hFFFF);
        send_word(1'b1, 16'hFFFF, 32'd10);
        send_word(1'b1, 16'hFFFF, 32'd65544);
        send_word(1'b1, 16'hFFFF, 32'd65545);
        send_word(1'b1, 16'hFFFF, 32'd131079);

        clock_ms = 32'd200000;
        phase(16'd10, SCALE_NUM_RST, SCALE_DEN_RST, 0, 0, 142);
        phase(16'd1, 16'hFFFF, 16'd1, 60, 0, 142);
        phase(16'd37, 16'd1, 16'hFFFF, 0, 60, 142);
        phase(16'hFFFF, 16'd5000, 16'd3, 11, 11, 142);
        clock_ms = 32'hFFFF_FF00;
        phase(16'd4, 16'd12345, 16'd77, 0, 0, 142);
        phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 65535)),
              CFG_W'($urandom_range(1, 65535)), 11, 11, 142);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[windowed_adc_average_scaler_top] OK");
        end else begin
            $display("[windowed_adc_average_scaler_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[windowed_adc_average_scaler_top] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wavs_pkg.sv
rtl/wavs_front.sv
rtl/wavs_queue.sv
rtl/wavs_back.sv
rtl/windowed_adc_average_scaler_top.sv
verif/tb_windowed_adc_average_scaler_top.sv
